// ===== src/esc_pkg.sv =====
// esc_pkg: shared types, constants and lookup functions for the epoch
// seconds to calendar block. No dependencies; imported by every module.
`default_nettype none

package esc_pkg;

    // input and output field widths
    localparam int EPOCH_W = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // 86400 = 2^7 * 675: the low 7 bits pass through, the rest divides by 675
    localparam int                  SOD_LOW_W   = 7;
    localparam int                  DAYS_W      = 16;
    localparam int                  DREM_W      = 10;
    localparam logic [DREM_W-1:0]   DAY_DIVISOR = 10'd675;
    localparam int                  SOD_W       = DREM_W + SOD_LOW_W;
    localparam int                  DVD_W       = EPOCH_W - SOD_LOW_W;
    localparam int                  DBACK_W     = DVD_W + 1;

    // days = (t >> 7) * ceil(2^35 / 675) >> 35, exact over the 25-bit range
    localparam int                     DAY_RECIP_W = 26;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP   = 26'd50903317;
    localparam int                     DAY_SHIFT   = 35;
    localparam int                     DAY_PROD_W  = DVD_W + DAY_RECIP_W;

    // hour = (sod >> 4) * ceil(2^21 / 225) >> 21, exact for sod < 86400
    localparam int                      MREM_W       = 12;
    localparam int                      HOUR_PRE     = 4;
    localparam int                      HOUR_RECIP_W = 14;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP   = 14'd9321;
    localparam int                      HOUR_SHIFT   = 21;
    localparam int                      HOUR_PROD_W  = SOD_W - HOUR_PRE + HOUR_RECIP_W;
    localparam logic [MREM_W-1:0]       HOUR_SECS    = 12'd3600;

    // minute = (rem >> 2) * ceil(2^14 / 15) >> 14, exact for rem < 3600
    localparam int                     MIN_PRE     = 2;
    localparam int                     MIN_RECIP_W = 11;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP   = 11'd1093;
    localparam int                     MIN_SHIFT   = 14;
    localparam int                     MIN_PROD_W  = MREM_W - MIN_PRE + MIN_RECIP_W;
    localparam logic [SEC_W-1:0]       MIN_SECS    = 6'd60;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 12'd1970;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd11;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic day_mul;
        logic day_rem;
        logic hour_mul;
        logic hour_rem;
        logic min_mul;
        logic min_rem;
        logic year_step;
        logic month_step;
    } esc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } esc_status_t;

    // leap rule over the reachable years 1970..2106: 2000 is a leap
    // century year, 2100 is the only century year that is not
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic result;
        result = (y[1:0] == 2'b00) && (y != 12'd2100);
        return result;
    endfunction

    function automatic logic [8:0] year_days(input logic [YEAR_W-1:0] y);
        logic [8:0] result;
        result = leap_year(y) ? 9'd366 : 9'd365;
        return result;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] result;
        case (m)
            4'd0:    result = 5'd31;
            4'd1:    result = leap ? 5'd29 : 5'd28;
            4'd2:    result = 5'd31;
            4'd3:    result = 5'd30;
            4'd4:    result = 5'd31;
            4'd5:    result = 5'd30;
            4'd6:    result = 5'd31;
            4'd7:    result = 5'd31;
            4'd8:    result = 5'd30;
            4'd9:    result = 5'd31;
            4'd10:   result = 5'd30;
            default: result = 5'd31;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== src/esc_ctrl.sv =====
// esc_ctrl: sequencing state machine for the calendar conversion.
// Depends on esc_pkg; drives esc_dp through command and status structs.
`default_nettype none

module esc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  esc_pkg::esc_status_t status,
    output esc_pkg::esc_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import esc_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DAYS  = 9'b000000010,
        ST_DREM  = 9'b000000100,
        ST_HOUR  = 9'b000001000,
        ST_HREM  = 9'b000010000,
        ST_MIN   = 9'b000100000,
        ST_MREM  = 9'b001000000,
        ST_YEAR  = 9'b010000000,
        ST_MONTH = 9'b100000000
    } esc_state_t;

    esc_state_t state_reg, state_next;
    logic       done_reg, done_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DAYS;
                end
            end
            // split into days and time of day, one multiply per cycle
            ST_DAYS:
            begin
                cmd.day_mul = 1'b1;
                state_next  = ST_DREM;
            end
            ST_DREM:
            begin
                cmd.day_rem = 1'b1;
                state_next  = ST_HOUR;
            end
            ST_HOUR:
            begin
                cmd.hour_mul = 1'b1;
                state_next   = ST_HREM;
            end
            ST_HREM:
            begin
                cmd.hour_rem = 1'b1;
                state_next   = ST_MIN;
            end
            ST_MIN:
            begin
                cmd.min_mul = 1'b1;
                state_next  = ST_MREM;
            end
            ST_MREM:
            begin
                cmd.min_rem = 1'b1;
                state_next  = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (status.year_fit)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                if (status.month_fit)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/esc_dp.sv =====
// esc_dp: datapath of the calendar conversion: reciprocal multiplies for
// days, hour and minute, year and month walks. Depends on esc_pkg.
`default_nettype none

module esc_dp (
    input  wire                                 clk,
    input  wire  [esc_pkg::EPOCH_W-1:0]         epoch_seconds,
    input  esc_pkg::esc_cmd_t                   cmd,
    output esc_pkg::esc_status_t                status,
    output logic [esc_pkg::YEAR_W-1:0]          year,
    output logic [esc_pkg::MONTH_W-1:0]         month,
    output logic [esc_pkg::DAY_W-1:0]           day,
    output logic [esc_pkg::HOUR_W-1:0]          hour,
    output logic [esc_pkg::MIN_W-1:0]           minute,
    output logic [esc_pkg::SEC_W-1:0]           second
);
    import esc_pkg::*;

    logic [DVD_W-1:0]       dvd_reg;
    logic [SOD_LOW_W-1:0]   sod_low_reg;
    logic [DAYS_W-1:0]      days_reg;
    logic [DREM_W-1:0]      drem_reg;
    logic [HOUR_W-1:0]      hour_reg;
    logic [MREM_W-1:0]      mrem_reg;
    logic [MIN_W-1:0]       minute_reg;
    logic [SEC_W-1:0]       second_reg;
    logic [YEAR_W-1:0]      year_reg;
    logic [MONTH_W-1:0]     mon_reg;

    logic [DAY_PROD_W-1:0]  day_prod;
    logic [DBACK_W-1:0]     day_back;
    logic [DBACK_W-1:0]     day_diff;
    logic [SOD_W-1:0]       sod;
    logic [HOUR_PROD_W-1:0] hour_prod;
    logic [SOD_W-1:0]       hour_back;
    logic [SOD_W-1:0]       hour_diff;
    logic [MIN_PROD_W-1:0]  min_prod;
    logic [MREM_W-1:0]      min_back;
    logic [MREM_W-1:0]      min_diff;
    logic [8:0]             ylen;
    logic [DAY_W-1:0]       mlen;

    // whole days and the remainder of the day division
    assign day_prod = DAY_PROD_W'(dvd_reg) * DAY_PROD_W'(DAY_RECIP);
    assign day_back = DBACK_W'(days_reg) * DBACK_W'(DAY_DIVISOR);
    assign day_diff = {1'b0, dvd_reg} - day_back;

    // hour and the seconds left in the hour
    assign sod       = {drem_reg, sod_low_reg};
    assign hour_prod = HOUR_PROD_W'(sod[SOD_W-1:HOUR_PRE]) * HOUR_PROD_W'(HOUR_RECIP);
    assign hour_back = SOD_W'(hour_reg) * SOD_W'(HOUR_SECS);
    assign hour_diff = sod - hour_back;

    // minute and second
    assign min_prod = MIN_PROD_W'(mrem_reg[MREM_W-1:MIN_PRE]) * MIN_PROD_W'(MIN_RECIP);
    assign min_back = MREM_W'(minute_reg) * MREM_W'(MIN_SECS);
    assign min_diff = mrem_reg - min_back;

    // lengths of the current year and month
    assign ylen = year_days(year_reg);
    assign mlen = month_days(mon_reg, leap_year(year_reg));

    assign status.year_fit  = (days_reg < {{(DAYS_W-9){1'b0}}, ylen});
    assign status.month_fit = (mon_reg == MONTH_DEC) ||
                              (days_reg < {{(DAYS_W-DAY_W){1'b0}}, mlen});

    // day count and calendar walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg     <= epoch_seconds[EPOCH_W-1:SOD_LOW_W];
            sod_low_reg <= epoch_seconds[SOD_LOW_W-1:0];
            year_reg    <= EPOCH_YEAR;
            mon_reg     <= MONTH_JAN;
        end
        else if (cmd.day_mul)
        begin
            days_reg <= day_prod[DAY_SHIFT +: DAYS_W];
        end
        else if (cmd.year_step)
        begin
            days_reg <= days_reg - {{(DAYS_W-9){1'b0}}, ylen};
            year_reg <= year_reg + 1'b1;
        end
        else if (cmd.month_step)
        begin
            days_reg <= days_reg - {{(DAYS_W-DAY_W){1'b0}}, mlen};
            mon_reg  <= mon_reg + 1'b1;
        end
    end

    // time of day registers
    always_ff @(posedge clk)
    begin
        if (cmd.day_rem)
        begin
            drem_reg <= day_diff[DREM_W-1:0];
        end
        if (cmd.hour_mul)
        begin
            hour_reg <= hour_prod[HOUR_SHIFT +: HOUR_W];
        end
        if (cmd.hour_rem)
        begin
            mrem_reg <= hour_diff[MREM_W-1:0];
        end
        if (cmd.min_mul)
        begin
            minute_reg <= min_prod[MIN_SHIFT +: MIN_W];
        end
        if (cmd.min_rem)
        begin
            second_reg <= min_diff[SEC_W-1:0];
        end
    end

    // result fields
    assign year   = year_reg;
    assign month  = mon_reg + 1'b1;
    assign day    = days_reg[DAY_W-1:0] + 1'b1;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

`default_nettype wire

// ===== src/epoch_seconds_to_calendar.sv =====
// Converts a count of seconds since 1970-01-01 00:00:00 into Gregorian date
// and time of day. A request is taken when start is high while busy is low;
// done pulses for one cycle with the result, which the receiver cannot stall.
// Reciprocal multiplies and back-subtractions in turn split the count into
// days, hour, minute and second (86400 = 675 * 128); then the years are
// walked from 1970 (up to 136), then the months (up to 11), and done is
// registered. Busy stays high until done, and a new request may be made in
// the cycle done is high.
// Depends on esc_pkg, esc_ctrl and esc_dp.
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [esc_pkg::EPOCH_W-1:0]  epoch_seconds,
    output logic                         done,
    output logic [esc_pkg::YEAR_W-1:0]   year,
    output logic [esc_pkg::MONTH_W-1:0]  month,
    output logic [esc_pkg::DAY_W-1:0]    day,
    output logic [esc_pkg::HOUR_W-1:0]   hour,
    output logic [esc_pkg::MIN_W-1:0]    minute,
    output logic [esc_pkg::SEC_W-1:0]    second
);
    import esc_pkg::*;

    esc_cmd_t    cmd;
    esc_status_t status;

    // sequencing
    esc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // arithmetic
    esc_dp u_dp (
        .clk           (clk),
        .epoch_seconds (epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

endmodule

`default_nettype wire

// ===== src/esc_checker.sv =====
// esc_checker: port-level checks of the calendar conversion, bound to the
// top level. Depends on esc_pkg and epoch_seconds_to_calendar.
`default_nettype none

module esc_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          start,
    input wire                          busy,
    input wire                          done,
    input wire [esc_pkg::YEAR_W-1:0]    year,
    input wire [esc_pkg::MONTH_W-1:0]   month,
    input wire [esc_pkg::DAY_W-1:0]     day,
    input wire [esc_pkg::HOUR_W-1:0]    hour,
    input wire [esc_pkg::MIN_W-1:0]     minute,
    input wire [esc_pkg::SEC_W-1:0]     second
);
    import esc_pkg::*;

    // a result never shows while a request is still in work
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted request makes the block busy and gives no result next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("request accepted without going busy");

    // date fields stay within the calendar
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (year >= 12'd1970 && year <= 12'd2106 &&
                  month >= 4'd1 && month <= 4'd12 &&
                  day >= 5'd1))
        else $error("date field out of range");

    // time of day fields stay within the clock
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("time field out of range");

    // february never runs past its leap length
    a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && month == 4'd2) |-> (day <= 5'd29))
        else $error("february day out of range");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .year   (year),
    .month  (month),
    .day    (day),
    .hour   (hour),
    .minute (minute),
    .second (second)
);

`default_nettype wire

// ===== tb/tb_epoch_seconds_to_calendar.sv =====
// Self-checking testbench for epoch_seconds_to_calendar: predicts each date from
// its own calendar walk and checks every done strobe against the oldest request.
// Depends on esc_pkg and the epoch_seconds_to_calendar RTL.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar;

    import esc_pkg::*;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam longint      MAX_EPOCH     = 64'hFFFF_FFFF;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          RANDOM_ITEMS  = 500;

    // expected date for one request, with the request kept for messages
    typedef struct {
        logic [EPOCH_W-1:0] source;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } civil_date_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [EPOCH_W-1:0] epoch_seconds = '0;
    logic               busy;
    logic               done;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;

    civil_date_t pending_dates [$];
    int          mismatch_count = 0;

    epoch_seconds_to_calendar u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .done          (done),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // gregorian leap rule, full form
    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_length(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    // m counts from 0 for january
    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        return (m == 1 && is_leap(y)) ? 29 : MONTH_LEN[m];
    endfunction

    // calendar walk: whole years, then whole months, then time of day
    function automatic civil_date_t civil_from_epoch(input logic [EPOCH_W-1:0] t);
        civil_date_t  c;
        int unsigned  secs;
        int unsigned  day_count;
        int unsigned  sod;
        int unsigned  yr;
        int unsigned  mon;
        secs      = t;
        day_count = secs / SECS_PER_DAY;
        sod       = secs % SECS_PER_DAY;
        yr        = FIRST_YEAR;
        while (day_count >= year_length(yr))
        begin
            day_count -= year_length(yr);
            yr++;
        end
        mon = 0;
        while (mon < 11 && day_count >= month_length(mon, yr))
        begin
            day_count -= month_length(mon, yr);
            mon++;
        end
        c.source = t;
        c.year   = YEAR_W'(yr);
        c.month  = MONTH_W'(mon + 1);
        c.day    = DAY_W'(day_count + 1);
        c.hour   = HOUR_W'(sod / SECS_PER_HOUR);
        c.minute = MIN_W'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
        c.second = SEC_W'(sod % SECS_PER_MIN);
        return c;
    endfunction

    // seconds count of a calendar instant, m and d counting from 1
    function automatic longint epoch_of(input int unsigned y, input int unsigned m,
                                        input int unsigned d, input int unsigned hh,
                                        input int unsigned mm, input int unsigned ss);
        longint days;
        days = 0;
        for (int unsigned yi = FIRST_YEAR; yi < y; yi++)
            days += year_length(yi);
        for (int unsigned mi = 0; mi + 1 < m; mi++)
            days += month_length(mi, y);
        days += d - 1;
        return days * SECS_PER_DAY + hh * SECS_PER_HOUR + mm * SECS_PER_MIN + ss;
    endfunction

    function automatic logic [EPOCH_W-1:0] clamp_epoch(input longint v);
        if (v < 0)
            return '0;
        if (v > MAX_EPOCH)
            return '1;
        return EPOCH_W'(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        mismatch_count++;
    endtask

    // hold start with the request until the block takes it; start stays high
    task automatic send_epoch(input logic [EPOCH_W-1:0] t);
        start         <= 1'b1;
        epoch_seconds <= t;
        do
            @(posedge clk);
        while (busy);
        pending_dates.push_back(civil_from_epoch(t));
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // pause the sender until every outstanding request has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    // result checker: done is a one-cycle strobe the receiver cannot stall
    always @(posedge clk)
    begin
        civil_date_t want;
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
                                          year, month, day, hour, minute, second));
            else
            begin
                want = pending_dates.pop_front();
                if (year !== want.year)
                    report_mismatch($sformatf("epoch %0d year got %0d want %0d",
                                              want.source, year, want.year));
                if (month !== want.month)
                    report_mismatch($sformatf("epoch %0d month got %0d want %0d",
                                              want.source, month, want.month));
                if (day !== want.day)
                    report_mismatch($sformatf("epoch %0d day got %0d want %0d",
                                              want.source, day, want.day));
                if (hour !== want.hour)
                    report_mismatch($sformatf("epoch %0d hour got %0d want %0d",
                                              want.source, hour, want.hour));
                if (minute !== want.minute)
                    report_mismatch($sformatf("epoch %0d minute got %0d want %0d",
                                              want.source, minute, want.minute));
                if (second !== want.second)
                    report_mismatch($sformatf("epoch %0d second got %0d want %0d",
                                              want.source, second, want.second));
            end
        end
    end

    // time-of-day rollovers and the extremes of the input word
    task automatic test_time_of_day_edges();
        send_epoch(32'd0);
        send_epoch(32'd1);
        send_epoch(32'd59);
        send_epoch(32'd60);
        send_epoch(32'd3599);
        send_epoch(32'd3600);
        send_epoch(32'd86399);
        send_epoch(32'd86400);
        send_epoch(32'hAAAA_AAAA);
        send_epoch(32'h5555_5555);
        send_epoch(32'hFFFF_FFFE);
        send_epoch(32'hFFFF_FFFF);
        idle_for(1);
    endtask

    // leap days, last day of leap years, the non-leap century 2100
    task automatic test_leap_boundaries();
        send_epoch(clamp_epoch(epoch_of(1970, 12, 31, 23, 59, 59)));
        send_epoch(clamp_epoch(epoch_of(1972, 2, 29, 0, 0, 0)));
        send_epoch(clamp_epoch(epoch_of(1972, 3, 1, 0, 0, 0)));
        send_epoch(clamp_epoch(epoch_of(1972, 12, 31, 23, 59, 59)));
        send_epoch(clamp_epoch(epoch_of(1973, 1, 1, 0, 0, 0)));
        send_epoch(clamp_epoch(epoch_of(2000, 2, 29, 12, 30, 30)));
        send_epoch(clamp_epoch(epoch_of(2000, 12, 31, 0, 0, 0)));
        send_epoch(clamp_epoch(epoch_of(2100, 2, 28, 23, 59, 59)));
        send_epoch(clamp_epoch(epoch_of(2100, 3, 1, 0, 0, 0)));
        send_epoch(clamp_epoch(epoch_of(2104, 12, 31, 23, 59, 59)));
        send_epoch(clamp_epoch(epoch_of(2106, 1, 1, 0, 0, 0)));
        idle_for(3);
    endtask

    // random stream in bursts: uniform words mixed with year and month ends
    task automatic test_random_stream();
        int          sent;
        int          burst;
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        longint      base;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst; i++)
            begin
                pick = $urandom_range(0, 3);
                y    = $urandom_range(FIRST_YEAR, 2104);
                m    = $urandom_range(1, 12);
                if (pick == 0)
                    base = epoch_of(y + 1, 1, 1, 0, 0, 0)
                           - longint'($urandom_range(0, 2 * SECS_PER_DAY))
                           + longint'($urandom_range(0, SECS_PER_DAY));
                else if (pick == 1)
                    base = epoch_of(y, m, 1, 0, 0, 0)
                           + longint'($urandom_range(0, SECS_PER_DAY))
                           - longint'($urandom_range(0, 3 * SECS_PER_DAY));
                else
                    base = longint'($urandom);
                send_epoch(clamp_epoch(base));
                sent++;
            end
            // gaps land anywhere in the block's work; some bursts run back to back
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 200));
        end
        idle_for(1);
    endtask

    // let the block empty out between requests, then resume
    task automatic test_idle_drain();
        for (int i = 0; i < 8; i++)
            send_epoch($urandom);
        wait_drained();
        idle_for($urandom_range(1, 20));
        for (int i = 0; i < 8; i++)
        begin
            send_epoch($urandom);
            if (i % 2 == 1)
                wait_drained();
        end
        start <= 1'b0;
    endtask

    // reset, tests in turn, drain and final verdict
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_time_of_day_edges();
        test_leap_boundaries();
        test_random_stream();
        test_idle_drain();
        @(posedge clk);
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
src/esc_pkg.sv
src/esc_ctrl.sv
src/esc_dp.sv
src/epoch_seconds_to_calendar.sv
src/esc_checker.sv
tb/tb_epoch_seconds_to_calendar.sv
